// File: sv/ship_deadblock_dip_replacement_top_defines.svh
// Assertion macros shared by the replacement policy RTL.
// Included by the top level only.
`ifndef SHIP_DEADBLOCK_DIP_REPLACEMENT_TOP_DEFINES_SVH
`define SHIP_DEADBLOCK_DIP_REPLACEMENT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SDR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/sdr_pkg.sv
// Package for the replacement policy: sizes, codes and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdr_pkg;
  localparam int SetCount   = 2048;
  localparam int WayCount   = 16;
  localparam int LeaderSets = 32;
  localparam int SigBits    = 6;
  localparam int PselBits   = 10;
  localparam int SetW       = $clog2(SetCount);
  localparam int WayW       = $clog2(WayCount);
  localparam int SigCount   = 1 << SigBits;
  localparam int LineW      = SetW + WayW;
  // one memory row per set: rrpv, dead counter, signature for every way
  localparam int WayBits    = 2 + 2 + SigBits;
  localparam int RowW       = WayCount * WayBits;
  localparam logic [PselBits-1:0] PselMax = {PselBits{1'b1}};
  localparam logic [PselBits-1:0] PselMid = {1'b1, {(PselBits-1){1'b0}}};
  localparam logic [1:0] RrpvMax = 2'd3;
  localparam logic ActQuery  = 1'b0;
  localparam logic ActUpdate = 1'b1;

  typedef struct packed {
    logic [1:0]         rrpv;
    logic [1:0]         dead;
    logic [SigBits-1:0] sig;
  } way_st_t;
endpackage
`default_nettype wire

// File: sv/sdr_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sdr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/ship_deadblock_dip_replacement_top.sv
// Replacement policy, one item at a time: accept, read set row and reuse counter (StRead),
// update and write back the row (StCalc), load the output register (StOut). The next item
// is accepted only after StOut has returned to idle.
// A full output register holds the last step. After every sweep interval of updates a
// sweep walks all SetCount rows, reading (StSwRd) and writing (StSwWr) each, stalling input.
// Reset is asynchronous, active low; a clearing pass over all SetCount rows runs before accept.
`timescale 1ns / 1ps
`default_nettype none
`include "ship_deadblock_dip_replacement_top_defines.svh"
module ship_deadblock_dip_replacement_top
  import sdr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i,  // sweep interval
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [10:0] set_index, [14:11] way_index, [30:15] valid_mask, [94:31] pc, [95] zero
  input  wire logic [95:0] s_axis_tdata,
  // [0] action, [1] hit
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] victim_way, [5:4] insert_priority, [7:6] zero
  output logic      [7:0]  m_axis_tdata
);
  localparam logic [2:0] StClear = 3'd0, StIdle = 3'd1, StRead = 3'd2,
                         StCalc = 3'd3, StOut = 3'd4, StSwRd = 3'd5,
                         StSwWr = 3'd6;

  logic [2:0] st_q, st_d;
  logic [19:0] period_q, acc_q, acc_d;
  logic [PselBits-1:0] psel_q, psel_d;
  logic [4:0] bipl_q, bipl_d, bipf_q, bipf_d;
  logic [SetW:0] sw_q, sw_d;
  logic act_q, hit_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic [WayCount-1:0] vld_q;
  logic [SigBits-1:0] sig_q, oldsig_q;
  logic [5:0] res_q, res_d;
  logic [7:0] out_q, out_d;
  logic ovld_q, ovld_d;
  logic sweep_q, sweep_d;

  logic we;
  logic [SetW-1:0] waddr, raddr;
  logic [RowW-1:0] wdata, rdata;
  logic reuse_we;
  logic [SigBits-1:0] reuse_waddr, reuse_raddr;
  logic [1:0] reuse_wdata, reuse_rdata;

  sdr_ram #(.Width(RowW), .Depth(SetCount)) u_row_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  sdr_ram #(.Width(2), .Depth(SigCount)) u_reuse_ram (
    .clk_i, .we_i(reuse_we), .waddr_i(reuse_waddr), .wdata_i(reuse_wdata),
    .raddr_i(reuse_raddr), .rdata_o(reuse_rdata)
  );

  assign s_axis_tready = (st_q == StIdle) && !sweep_q;
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = out_q;

  way_st_t row_in [WayCount];
  way_st_t row_out [WayCount];
  way_st_t cur, nw;
  logic [1:0] top, lift, ins, rold, rnew, rsig_upd;
  logic [WayW-1:0] vic;
  logic found;
  logic [SigBits-1:0] oldsig;
  logic upd_en;

  always_comb begin
    for (int w = 0; w < WayCount; w++) begin
      row_in[w] = rdata[w*WayBits +: WayBits];
    end
  end

  // victim and aging logic on the read row
  always_comb begin
    vic = '0;
    found = 1'b0;
    top = '0;
    for (int w = 0; w < WayCount; w++) row_out[w] = row_in[w];
    for (int w = WayCount-1; w >= 0; w--) begin
      if (!vld_q[w]) begin vic = WayW'(w); found = 1'b1; end
    end
    if (!found) begin
      for (int w = WayCount-1; w >= 0; w--) begin
        if (row_in[w].rrpv == RrpvMax && row_in[w].dead == 2'd0) begin
          vic = WayW'(w); found = 1'b1;
        end
      end
    end
    if (!found) begin
      for (int w = 0; w < WayCount; w++) if (row_in[w].rrpv > top) top = row_in[w].rrpv;
      lift = RrpvMax - top;
      for (int w = 0; w < WayCount; w++) row_out[w].rrpv = row_in[w].rrpv + lift;
      for (int w = WayCount-1; w >= 0; w--) begin
        if (row_in[w].rrpv == top) vic = WayW'(w);
      end
    end else begin
      lift = '0;
    end
  end

  // update logic; reuse_rdata holds the counter of the access signature here
  always_comb begin
    cur = row_in[way_q];
    oldsig = cur.sig;
    nw = cur;
    psel_d = psel_q;
    bipl_d = bipl_q;
    bipf_d = bipf_q;
    rold = reuse_rdata;
    rsig_upd = reuse_rdata;
    if (hit_q) begin
      if (rsig_upd != 2'd3) rsig_upd = rsig_upd + 2'd1;
      if (cur.dead != 2'd3) nw.dead = cur.dead + 2'd1;
      rnew = rsig_upd;
    end else begin
      // the old signature counter drops first; it only matters here when equal
      if (rold != 2'd0) rold = rold - 2'd1;
      nw.dead = 2'd0;
      rnew = (oldsig == sig_q) ? rold : reuse_rdata;
    end
    if (32'(set_q) < LeaderSets) begin
      ins = RrpvMax;
      if (hit_q) begin if (psel_q != PselMax) psel_d = psel_q + 1'b1; end
      else if (psel_q != '0) psel_d = psel_q - 1'b1;
    end else if (32'(set_q) < 2*LeaderSets) begin
      ins = (bipl_q == '0) ? 2'd0 : RrpvMax;
      bipl_d = bipl_q + 5'd1;
      if (hit_q) begin if (psel_q != '0) psel_d = psel_q - 1'b1; end
      else if (psel_q != PselMax) psel_d = psel_q + 1'b1;
    end else if (psel_q >= PselMid) begin
      ins = RrpvMax;
    end else begin
      ins = (bipf_q == '0) ? 2'd0 : RrpvMax;
      bipf_d = bipf_q + 5'd1;
    end
    if (rnew >= 2'd2) ins = 2'd0;
    nw.rrpv = ins;
    nw.sig = sig_q;
    upd_en = (st_q == StCalc) && (act_q == ActUpdate);
  end

  always_comb begin
    st_d = st_q;
    sw_d = sw_q;
    acc_d = acc_q;
    res_d = res_q;
    out_d = out_q;
    ovld_d = ovld_q;
    sweep_d = sweep_q;
    we = 1'b0;
    waddr = set_q;
    wdata = '0;
    raddr = set_q;
    reuse_we = 1'b0;
    reuse_waddr = sig_q;
    reuse_wdata = rsig_upd;
    reuse_raddr = sig_q;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (st_q)
      StClear: begin
        we = 1'b1;
        waddr = sw_q[SetW-1:0];
        for (int w = 0; w < WayCount; w++) begin
          wdata[w*WayBits +: WayBits] = {RrpvMax, 2'd0, {SigBits{1'b0}}};
        end
        reuse_we = 1'b1;
        reuse_waddr = sw_q[SigBits-1:0];
        reuse_wdata = 2'd1;
        sw_d = sw_q + 1'b1;
        if (sw_q[SetW-1:0] == SetW'(SetCount-1)) st_d = StIdle;
      end
      StIdle: begin
        if (sweep_q) begin
          sw_d = '0;
          sweep_d = 1'b0;
          st_d = StSwRd;
          raddr = '0;
        end else if (acc_in) st_d = StRead;
      end
      StRead: st_d = StCalc;
      StCalc: begin
        we = 1'b1;
        // fetch the counter of the line's old signature for the fill decrement
        reuse_raddr = oldsig;
        if (act_q == ActQuery) begin
          for (int w = 0; w < WayCount; w++) wdata[w*WayBits +: WayBits] = row_out[w];
          res_d = {2'd0, vic};
        end else begin
          for (int w = 0; w < WayCount; w++) begin
            wdata[w*WayBits +: WayBits] = (WayW'(w) == way_q) ? nw : row_in[w];
          end
          res_d = {ins, 4'd0};
          if (hit_q) reuse_we = 1'b1;
          if (acc_q + 20'd1 >= period_q) begin
            acc_d = '0;
            sweep_d = 1'b1;
          end else acc_d = acc_q + 20'd1;
        end
        st_d = StOut;
      end
      StOut: begin
        reuse_raddr = oldsig_q;
        // hold until the output register is free
        if (!ovld_q || m_axis_tready) begin
          out_d = {2'd0, res_q};
          ovld_d = 1'b1;
          st_d = StIdle;
          if (act_q == ActUpdate && !hit_q) begin
            reuse_we = 1'b1;
            reuse_waddr = oldsig_q;
            reuse_wdata = (reuse_rdata != 2'd0) ? reuse_rdata - 2'd1 : 2'd0;
          end
        end
      end
      StSwRd: begin
        raddr = sw_q[SetW-1:0];
        st_d = StSwWr;
      end
      StSwWr: begin
        we = 1'b1;
        waddr = sw_q[SetW-1:0];
        for (int w = 0; w < WayCount; w++) begin
          wdata[w*WayBits +: WayBits] = {row_in[w].rrpv,
            (row_in[w].dead != 2'd0) ? row_in[w].dead - 2'd1 : 2'd0, row_in[w].sig};
        end
        sw_d = sw_q + 1'b1;
        raddr = SetW'(sw_q + 1'b1);
        if (sw_q[SetW-1:0] == SetW'(SetCount-1)) st_d = StIdle;
        else st_d = StSwRd;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      sw_q <= '0;
      period_q <= 20'd100000;
      acc_q <= '0;
      psel_q <= PselMid;
      bipl_q <= '0;
      bipf_q <= '0;
      ovld_q <= 1'b0;
      sweep_q <= 1'b0;
    end else begin
      st_q <= st_d;
      sw_q <= sw_d;
      acc_q <= acc_d;
      ovld_q <= ovld_d;
      sweep_q <= sweep_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (upd_en) begin
        psel_q <= psel_d;
        bipl_q <= bipl_d;
        bipf_q <= bipf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    res_q <= res_d;
    if (st_q == StCalc) oldsig_q <= oldsig;
    if (acc_in) begin
      act_q <= s_axis_tuser[0];
      set_q <= SetW'(s_axis_tdata[10:0]);
      way_q <= WayW'(s_axis_tdata[14:11]);
      vld_q <= s_axis_tdata[15 +: WayCount];
      sig_q <= s_axis_tdata[33 +: SigBits];
      hit_q <= s_axis_tuser[1];
    end
  end

  `SDR_ASSERT_IMP(a_no_accept_busy, st_q != StIdle, !s_axis_tready, "accept while busy")
  `SDR_ASSERT_NXT(a_accept_read, acc_in, st_q == StRead, "accepted item not read")
  `SDR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `SDR_ASSERT_IMP(a_out_pad, m_axis_tvalid, m_axis_tdata[7:6] == 2'b00,
                  "result padding not zero")
endmodule
`default_nettype wire
